// ===== sv/cce_pkg.sv =====
// ---------------------------------------------------------------------------
// cce_pkg: shared types and constants for the Chebyshev series evaluator
// Field widths, request and register codes, state encoding and the
// configuration bundle passed from the register block to the engine.
// ---------------------------------------------------------------------------
`default_nettype none

package cce_pkg;

    // Default highest coefficient index held in the table
    localparam int MAX_DEGREE_DEF = 63;

    // Field widths
    localparam int DATA_W  = 32;
    localparam int DEG_W   = 6;
    localparam int REQ_W   = 2;
    localparam int IDX_W   = 6;
    localparam int ACC_W   = 48;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Saturation bounds (raw Q16.16 and Q32.16 units)
    localparam longint ACC_LIM   = 64'sd140737488355327;
    localparam longint RES_MAX_L = 64'sd2147483647;
    localparam longint RES_MIN_L = -64'sd2147483648;

    // Register reset values
    localparam logic [DATA_W-1:0] SCALE_RESET  = 32'h0001_0000;
    localparam logic [DATA_W-1:0] OFFSET_RESET = 32'h0000_0000;

    // Register indexes (word address)
    localparam logic [1:0] REG_DEGREE = 2'd0;
    localparam logic [1:0] REG_SCALE  = 2'd1;
    localparam logic [1:0] REG_OFFSET = 2'd2;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE   = 2'd0,
        REQ_T_VALUE = 2'd1,
        REQ_U_VALUE = 2'd2,
        REQ_T_DERIV = 2'd3
    } t_req_kind;

    // Engine sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULX,
        ST_UADD,
        ST_STEP_A,
        ST_STEP_B,
        ST_DONE
    } t_eng_state;

    // Configuration bundle
    typedef struct packed {
        logic [DEG_W-1:0]         degree;
        logic signed [DATA_W-1:0] scale;
        logic signed [DATA_W-1:0] offset;
    } t_cfg;

endpackage

`default_nettype wire

// ===== sv/cce_req_if.sv =====
// ---------------------------------------------------------------------------
// cce_req_if: request channel
// Valid/ready channel carrying coefficient writes and evaluate requests.
// ---------------------------------------------------------------------------
`default_nettype none

interface cce_req_if;
    import cce_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [IDX_W-1:0]         coeff_index;
    logic signed [DATA_W-1:0] coeff_value;
    logic signed [DATA_W-1:0] point_x;

    modport source (
        output valid, req_type, coeff_index, coeff_value, point_x,
        input  ready
    );

    modport sink (
        input  valid, req_type, coeff_index, coeff_value, point_x,
        output ready
    );

endinterface

`default_nettype wire

// ===== sv/cce_rsp_if.sv =====
// ---------------------------------------------------------------------------
// cce_rsp_if: result channel
// Valid/ready channel carrying the saturated series result and its flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface cce_rsp_if;
    import cce_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_value;
    logic                     saturated;

    modport source (
        output valid, result_value, saturated,
        input  ready
    );

    modport sink (
        input  valid, result_value, saturated,
        output ready
    );

endinterface

`default_nettype wire

// ===== sv/cce_regs.sv =====
// ---------------------------------------------------------------------------
// cce_regs: configuration register block
// APB-style slave holding degree, interval scale and interval offset.
// ---------------------------------------------------------------------------
`default_nettype none

module cce_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [cce_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [cce_pkg::PDATA_W-1:0]  pwdata,
    output logic      [cce_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    output cce_pkg::t_cfg                     o_cfg
);
    import cce_pkg::*;

    logic [DEG_W-1:0]  r_degree;
    logic [DATA_W-1:0] r_scale;
    logic [DATA_W-1:0] r_offset;
    logic              wr_stb;
    logic [1:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_stb  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Capture register writes on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= '0;
            r_scale  <= SCALE_RESET;
            r_offset <= OFFSET_RESET;
        end else if (wr_stb) begin
            unique case (reg_idx)
                REG_DEGREE: r_degree <= pwdata[DEG_W-1:0];
                REG_SCALE:  r_scale  <= pwdata;
                REG_OFFSET: r_offset <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_DEGREE: prdata = {{(PDATA_W-DEG_W){1'b0}}, r_degree};
            REG_SCALE:  prdata = r_scale;
            REG_OFFSET: prdata = r_offset;
            default:    prdata = '0;
        endcase
    end

    assign o_cfg.degree = r_degree;
    assign o_cfg.scale  = r_scale;
    assign o_cfg.offset = r_offset;

endmodule

`default_nettype wire

// ===== sv/cce_coeff_mem.sv =====
// ---------------------------------------------------------------------------
// cce_coeff_mem: coefficient table
// Synchronous one-write one-read memory with a registered read port and a
// zeroing sweep after reset, one entry per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module cce_coeff_mem #(
    parameter int MAX_DEGREE = cce_pkg::MAX_DEGREE_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_we,
    input  wire logic [$clog2(MAX_DEGREE+1)-1:0]     i_waddr,
    input  wire logic [cce_pkg::DATA_W-1:0]          i_wdata,
    input  wire logic [$clog2(MAX_DEGREE+1)-1:0]     i_raddr,
    output logic      [cce_pkg::DATA_W-1:0]          o_rdata,
    output logic                                     o_busy
);
    import cce_pkg::*;

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int IW    = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic              r_clr_busy;
    logic [IW-1:0]     r_clr_addr;

    // Storage: sweep writes zero, otherwise take the request write
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // Advance the zeroing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + IW'(1);
            if (r_clr_addr == IW'(MAX_DEGREE)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

`default_nettype wire

// ===== sv/cce_engine.sv =====
// ---------------------------------------------------------------------------
// cce_engine: Clenshaw recurrence sequencer and datapath
// Maps x to u, walks the coefficient table from the top index down with a
// multiply/combine step, and holds the result in an output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module cce_engine #(
    parameter int MAX_DEGREE = cce_pkg::MAX_DEGREE_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire cce_pkg::t_cfg                       i_cfg,
    input  wire logic                                i_mem_busy,
    input  wire logic [cce_pkg::DATA_W-1:0]          i_mem_rdata,
    output logic                                     o_mem_we,
    output logic      [$clog2(MAX_DEGREE+1)-1:0]     o_mem_waddr,
    output logic      [cce_pkg::DATA_W-1:0]          o_mem_wdata,
    output logic      [$clog2(MAX_DEGREE+1)-1:0]     o_mem_raddr,
    cce_req_if.sink                                  i_req,
    cce_rsp_if.source                                o_rsp
);
    import cce_pkg::*;

    localparam int IW = $clog2(MAX_DEGREE + 1);
    localparam int NW = (IW > DEG_W) ? IW : DEG_W;
    localparam int CW = DATA_W + IW + 1;
    localparam int SW = ((CW > ACC_W + 1) ? CW : ACC_W + 1) + 2;
    localparam int UW = ACC_W + 1;

    localparam logic signed [63:0]   P_MAX = ACC_LIM;
    localparam logic signed [63:0]   P_MIN = -ACC_LIM;
    localparam logic signed [SW-1:0] B_MAX = SW'(ACC_LIM);
    localparam logic signed [SW-1:0] B_MIN = SW'(-ACC_LIM);
    localparam logic signed [SW-1:0] R_MAX = SW'(RES_MAX_L);
    localparam logic signed [SW-1:0] R_MIN = SW'(RES_MIN_L);
    localparam logic signed [UW-1:0] U_MAX = UW'(RES_MAX_L);
    localparam logic signed [UW-1:0] U_MIN = UW'(RES_MIN_L);

    // Sequencer
    t_eng_state r_state, n_state;
    logic       req_ready;
    logic       in_fire;
    logic       out_free;
    logic       out_load;

    // Request decode
    t_req_kind     in_kind;
    logic [NW-1:0] deg_ext;
    logic [NW-1:0] idx_ext;
    logic [IW-1:0] n_cur;
    logic          in_eval;
    logic          in_empty;
    logic [IW-1:0] in_fin;

    // Item state
    t_req_kind                r_kind;
    logic signed [DATA_W-1:0] r_x;
    logic [IW-1:0]            r_n;
    logic [IW-1:0]            r_k, n_k;
    logic                     r_final;
    logic                     r_flag;
    logic signed [63:0]       r_prod;
    logic signed [DATA_W-1:0] r_u;
    logic signed [ACC_W-1:0]  r_b1, r_b2;
    logic signed [63:0]       r_phi;
    logic signed [ACC_W:0]    r_plo;
    logic signed [CW-1:0]     r_cw;
    logic signed [DATA_W-1:0] r_res;

    // Output stage
    logic                     r_ovalid;
    logic signed [DATA_W-1:0] r_oval;
    logic                     r_osat;

    // Step arithmetic
    logic [IW:0]              lo_k;
    logic                     last;
    logic [IW-1:0]            fin_addr;
    logic [IW:0]              weight;
    logic signed [CW-1:0]     cw_next;
    logic signed [UW-1:0]     u_sum;
    logic signed [DATA_W-1:0] u_sat;
    logic                     u_clip;
    logic signed [63:0]       plo_ext;
    logic signed [63:0]       mq_sum;
    logic signed [ACC_W-1:0]  mq;
    logic                     mq_clip;
    logic signed [SW-1:0]     mq_ext;
    logic signed [SW-1:0]     cw_ext;
    logic signed [SW-1:0]     b2_ext;
    logic signed [SW-1:0]     b_sum;
    logic signed [ACC_W-1:0]  b_sat;
    logic                     b_clip;
    logic signed [DATA_W-1:0] res_sat;
    logic                     res_clip;

    // Decode the incoming request
    always_comb begin
        in_kind  = t_req_kind'(i_req.req_type);
        deg_ext  = NW'(i_cfg.degree);
        idx_ext  = NW'(i_req.coeff_index);
        n_cur    = (deg_ext > NW'(MAX_DEGREE)) ? IW'(MAX_DEGREE) : IW'(deg_ext);
        in_eval  = (in_kind != REQ_WRITE);
        in_fin   = (in_kind == REQ_T_DERIV) ? IW'(1) : '0;
        in_empty = (in_kind == REQ_T_DERIV) ? (n_cur <= IW'(1)) : (n_cur == '0);
    end

    assign in_fire  = i_req.valid && req_ready;
    assign out_free = !r_ovalid || o_rsp.ready;

    // Coefficient writes go straight to the table
    assign o_mem_we    = in_fire && (in_kind == REQ_WRITE) && (idx_ext <= NW'(MAX_DEGREE));
    assign o_mem_waddr = IW'(idx_ext);
    assign o_mem_wdata = i_req.coeff_value;
    assign o_mem_raddr = n_k;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_fire && in_eval) n_state = ST_MULX;
            ST_MULX:   n_state = ST_UADD;
            ST_UADD:   n_state = (r_kind == REQ_T_DERIV && r_n == '0) ? ST_DONE : ST_STEP_A;
            ST_STEP_A: n_state = ST_STEP_B;
            ST_STEP_B: n_state = r_final ? ST_DONE : ST_STEP_A;
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        req_ready = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: req_ready = !i_mem_busy;
            ST_DONE: out_load  = out_free;
            default: ;
        endcase
    end

    assign i_req.ready = req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Table walk: the read always targets the next index, so the registered
    // read data matches r_k in every cycle
    always_comb begin
        lo_k     = (r_kind == REQ_T_DERIV) ? (IW+1)'(2) : (IW+1)'(1);
        last     = ({1'b0, r_k} == lo_k);
        fin_addr = (r_kind == REQ_T_DERIV) ? IW'(1) : '0;
        n_k      = r_k;
        if (r_state == ST_IDLE && in_fire && in_eval) begin
            n_k = in_empty ? in_fin : n_cur;
        end else if (r_state == ST_STEP_B && !r_final) begin
            n_k = last ? fin_addr : r_k - IW'(1);
        end
    end

    // Normalized coordinate
    always_comb begin
        u_sum  = $signed({{(UW-DATA_W){i_cfg.offset[DATA_W-1]}}, i_cfg.offset})
               + $signed({r_prod[63], r_prod[63:16]});
        u_clip = (u_sum > U_MAX) || (u_sum < U_MIN);
        if (u_sum > U_MAX) begin
            u_sat = DATA_W'(RES_MAX_L);
        end else if (u_sum < U_MIN) begin
            u_sat = DATA_W'(RES_MIN_L);
        end else begin
            u_sat = u_sum[DATA_W-1:0];
        end
    end

    // Weighted coefficient: index times entry inside the derivative loop
    always_comb begin
        weight  = (r_kind == REQ_T_DERIV && !r_final) ? {1'b0, r_k} : (IW+1)'(1);
        cw_next = $signed(i_mem_rdata) * $signed(weight);
    end

    // Combine: floor(u*b1) from parts, then 2*p - b2 + c (final T: p - b2 + c)
    always_comb begin
        plo_ext = {{(64-(ACC_W+1-16)){r_plo[ACC_W]}}, r_plo[ACC_W:16]};
        mq_sum  = r_phi + plo_ext;
        mq_clip = (mq_sum > P_MAX) || (mq_sum < P_MIN);
        if (mq_sum > P_MAX) begin
            mq = ACC_W'(ACC_LIM);
        end else if (mq_sum < P_MIN) begin
            mq = ACC_W'(-ACC_LIM);
        end else begin
            mq = mq_sum[ACC_W-1:0];
        end
        mq_ext = {{(SW-ACC_W){mq[ACC_W-1]}}, mq};
        cw_ext = {{(SW-CW){r_cw[CW-1]}}, r_cw};
        b2_ext = {{(SW-ACC_W){r_b2[ACC_W-1]}}, r_b2};
        if (r_final && r_kind == REQ_T_VALUE) begin
            b_sum = mq_ext + cw_ext - b2_ext;
        end else begin
            b_sum = (mq_ext <<< 1) + cw_ext - b2_ext;
        end
        b_clip = (b_sum > B_MAX) || (b_sum < B_MIN);
        if (b_sum > B_MAX) begin
            b_sat = ACC_W'(ACC_LIM);
        end else if (b_sum < B_MIN) begin
            b_sat = ACC_W'(-ACC_LIM);
        end else begin
            b_sat = b_sum[ACC_W-1:0];
        end
        res_clip = (b_sum > R_MAX) || (b_sum < R_MIN);
        if (b_sum > R_MAX) begin
            res_sat = DATA_W'(RES_MAX_L);
        end else if (b_sum < R_MIN) begin
            res_sat = DATA_W'(RES_MIN_L);
        end else begin
            res_sat = b_sum[DATA_W-1:0];
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && in_eval) begin
                    r_kind  <= in_kind;
                    r_x     <= i_req.point_x;
                    r_n     <= n_cur;
                    r_final <= in_empty;
                    r_b1    <= '0;
                    r_b2    <= '0;
                end
            end
            ST_MULX: begin
                r_prod <= $signed(i_cfg.scale) * r_x;
            end
            ST_UADD: begin
                r_u    <= u_sat;
                r_flag <= u_clip;
                r_res  <= '0;
            end
            ST_STEP_A: begin
                r_phi <= r_u * $signed(r_b1[ACC_W-1:16]);
                r_plo <= r_u * $signed({1'b0, r_b1[15:0]});
                r_cw  <= cw_next;
            end
            ST_STEP_B: begin
                if (r_final) begin
                    r_res  <= res_sat;
                    r_flag <= r_flag | mq_clip | res_clip;
                end else begin
                    r_b1    <= b_sat;
                    r_b2    <= r_b1;
                    r_flag  <= r_flag | mq_clip | b_clip;
                    r_final <= last;
                end
            end
            default: ;
        endcase
    end

    // Output stage: hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oval <= r_res;
            r_osat <= r_flag;
        end
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.result_value = r_oval;
    assign o_rsp.saturated    = r_osat;

    // Table writes only between evaluations and after the zeroing sweep
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (r_state == ST_IDLE) && !i_mem_busy)
        else $error("coefficient write outside idle");

    // Recurrence index stays within the loop bounds
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP_B && !r_final) |->
            ({1'b0, r_k} >= lo_k) && ({1'b0, r_k} <= (IW+1)'(MAX_DEGREE)))
        else $error("recurrence index out of range");

    // Final combine always hands over to the output stage
    a_final_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP_B && r_final) |=> (r_state == ST_DONE))
        else $error("final step did not complete");

    // A blocked result waits with its value intact
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !out_free) |=> (r_state == ST_DONE) && $stable(r_res))
        else $error("pending result lost");

endmodule

`default_nettype wire

// ===== sv/chebyshev_clenshaw_eval.sv =====
// ---------------------------------------------------------------------------
// chebyshev_clenshaw_eval: Chebyshev series evaluator, top level
// Requests arrive on i_req (valid/ready). A write request (req_type 0)
// stores coeff_value at coeff_index and gives no result.
// An evaluate request (T value, U value, T derivative) maps point_x to
// u = offset + scale*x and runs the Clenshaw recurrence over the table,
// returning one saturated Q16.16 result with a clip flag on o_rsp.
// After the request transfer the engine forms scale*x (ST_MULX), then u
// (ST_UADD), then steps down the table from the effective degree with one
// multiply/combine pass over ST_STEP_A and ST_STEP_B per index, to index 0
// for T and U and index 1 for the derivative; the result is handed on in
// ST_DONE and the request port reopens once the engine is back in ST_IDLE.
// The result sits in an output register; the next request is taken while it
// waits. A second result waits inside the engine until the first is
// transferred, and the request port stays closed meanwhile.
// After reset all MAX_DEGREE+1 table entries (64 at the default) are swept
// to zero with the request port closed; register writes are taken
// throughout. Registers: degree at 0x0, scale at 0x4, offset at 0x8.
// ---------------------------------------------------------------------------
`default_nettype none

module chebyshev_clenshaw_eval #(
    parameter int MAX_DEGREE = cce_pkg::MAX_DEGREE_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    cce_req_if.sink                           i_req,
    cce_rsp_if.source                         o_rsp,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [cce_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [cce_pkg::PDATA_W-1:0]  pwdata,
    output logic      [cce_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);
    import cce_pkg::*;

    localparam int IW = $clog2(MAX_DEGREE + 1);

    t_cfg              cfg;
    logic              mem_busy;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [IW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    // Configuration registers
    cce_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Coefficient table
    cce_coeff_mem #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    // Recurrence engine
    cce_engine #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_mem_busy  (mem_busy),
        .i_mem_rdata (mem_rdata),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_req       (i_req),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

// ===== test/chebyshev_clenshaw_eval_tb.sv =====
// ---------------------------------------------------------------------------
// chebyshev_clenshaw_eval_tb: self-checking bench for the Chebyshev evaluator
// Walks a short directed table, then random phases, each under its own
// degree/scale/offset setting. A bit-accurate fixed-point Clenshaw predictor
// computes results not given in the directed table; all are matched in order
// against the result channel while both channels idle and stall at random.
// ---------------------------------------------------------------------------

module chebyshev_clenshaw_eval_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cce_pkg::*;

    localparam int N_DIRECTED  = 26;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 100;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 140;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     sat;
    } t_series_result;

    // One row of the directed table: a register write or a request
    typedef struct {
        bit                       is_cfg;
        logic [1:0]               reg_sel;
        logic [DATA_W-1:0]        cfg_data;
        t_req_kind                kind;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] cval;
        logic signed [DATA_W-1:0] x;
        bit                       typed;
        t_series_result           res;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    cce_req_if req_bus ();
    cce_rsp_if rsp_bus ();

    // Predictor state: coefficient table and register copies
    logic signed [DATA_W-1:0] coef_tab [0:MAX_DEGREE_DEF];
    logic [DEG_W-1:0]         model_degree;
    logic signed [DATA_W-1:0] model_scale;
    logic signed [DATA_W-1:0] model_offset;

    t_series_result pending_results [$];
    int             mismatch_count = 0;
    bit             hold_request   = 0;
    bit             no_idle        = 0;

    t_stim_row directed_rows [N_DIRECTED];

    chebyshev_clenshaw_eval uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Clip to [lo, hi] and note any clipping
    function automatic longint sat_to(input logic signed [95:0] v, input longint lo,
                                      input longint hi, inout bit clipped);
        if (v > hi) begin
            clipped = 1'b1;
            return hi;
        end
        if (v < lo) begin
            clipped = 1'b1;
            return lo;
        end
        return longint'(v);
    endfunction

    // floor(a*b / 2^16), clipped to the recurrence accumulator
    function automatic longint q_mul(input longint a, input longint b, inout bit clipped);
        logic signed [95:0] wa;
        logic signed [95:0] wb;
        logic signed [95:0] prod;
        wa   = a;
        wb   = b;
        prod = (wa * wb) >>> 16;
        return sat_to(prod, -ACC_LIM, ACC_LIM, clipped);
    endfunction

    // Expected result of one evaluate request under the current setting
    function automatic t_series_result clenshaw_eval(input t_req_kind kind,
                                                     input logic signed [DATA_W-1:0] x);
        t_series_result res;
        longint         u;
        longint         b;
        longint         b1;
        longint         b2;
        longint         r;
        bit             clipped;
        int             n;
        clipped = 1'b0;
        b1      = 0;
        b2      = 0;
        n       = model_degree;
        u = longint'(model_offset) + ((longint'(model_scale) * longint'(x)) >>> 16);
        u = sat_to(u, RES_MIN_L, RES_MAX_L, clipped);
        if (kind == REQ_T_DERIV) begin
            // Derivative runs on k*a[k]; degree zero gives zero
            if (n == 0) begin
                r = 0;
            end else begin
                for (int j = n - 1; j > 0; j--) begin
                    b  = 2 * q_mul(u, b1, clipped) - b2
                         + longint'(j + 1) * longint'(coef_tab[j + 1]);
                    b2 = b1;
                    b1 = sat_to(b, -ACC_LIM, ACC_LIM, clipped);
                end
                r = 2 * q_mul(u, b1, clipped) - b2 + longint'(coef_tab[1]);
            end
        end else begin
            for (int j = n; j > 0; j--) begin
                b  = 2 * q_mul(u, b1, clipped) - b2 + longint'(coef_tab[j]);
                b2 = b1;
                b1 = sat_to(b, -ACC_LIM, ACC_LIM, clipped);
            end
            if (kind == REQ_T_VALUE) begin
                r = q_mul(u, b1, clipped) - b2 + longint'(coef_tab[0]);
            end else begin
                r = 2 * q_mul(u, b1, clipped) - b2 + longint'(coef_tab[0]);
            end
        end
        res.value = DATA_W'(sat_to(r, RES_MIN_L, RES_MAX_L, clipped));
        res.sat   = clipped;
        return res;
    endfunction

    function automatic t_stim_row cfg_row(input logic [1:0] sel, input logic [DATA_W-1:0] data);
        t_stim_row row;
        row          = '{default: '0, kind: REQ_WRITE, res: '{default: '0}};
        row.is_cfg   = 1'b1;
        row.reg_sel  = sel;
        row.cfg_data = data;
        return row;
    endfunction

    function automatic t_stim_row item_row(input t_req_kind kind, input logic [IDX_W-1:0] idx,
                                           input logic signed [DATA_W-1:0] cval,
                                           input logic signed [DATA_W-1:0] x);
        t_stim_row row;
        row      = '{default: '0, kind: REQ_WRITE, res: '{default: '0}};
        row.kind = kind;
        row.idx  = idx;
        row.cval = cval;
        row.x    = x;
        return row;
    endfunction

    function automatic t_stim_row typed_row(input t_req_kind kind,
                                            input logic signed [DATA_W-1:0] x,
                                            input logic signed [DATA_W-1:0] value,
                                            input logic sat);
        t_stim_row row;
        row           = item_row(kind, '0, '0, x);
        row.typed     = 1'b1;
        row.res.value = value;
        row.res.sat   = sat;
        return row;
    endfunction

    // Mostly small values within +-span, some full-range, some extremes
    function automatic logic [DATA_W-1:0] rand_value(input int unsigned span);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70) return $urandom_range(0, 2 * span) - span;
        if (pick < 90) return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // Register write: setup phase, access phase held until pready, then idle
    task automatic cfg_write(input logic [1:0] sel, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_DEGREE: model_degree = data[DEG_W-1:0];
            REG_SCALE:  model_scale  = data;
            REG_OFFSET: model_offset = data;
            default:    ;
        endcase
        @(posedge i_clk);
    endtask

    // Drop valid and wait until every expected result has been transferred
    task automatic settle();
        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Offer one request after a random gap; on transfer, update the predictor
    task automatic send_item(input t_req_kind kind, input logic [IDX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] cval,
                             input logic signed [DATA_W-1:0] x,
                             input bit typed, input t_series_result typed_res);
        while (!no_idle && $urandom_range(99) < 20) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.req_type    <= kind;
        req_bus.coeff_index <= idx;
        req_bus.coeff_value <= cval;
        req_bus.point_x     <= x;
        do @(posedge i_clk); while (!req_bus.ready);
        if (kind == REQ_WRITE) begin
            coef_tab[idx] = cval;
        end else if (typed) begin
            pending_results.insert(pending_results.size(), typed_res);
        end else begin
            pending_results.insert(pending_results.size(), clenshaw_eval(kind, x));
        end
    endtask

    // Result side: check each transfer, then pick ready for the next cycle
    initial begin
        t_series_result want;
        int             stall_left;
        stall_left    = 0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: result_value %0d saturated %0b",
                           rsp_bus.result_value, rsp_bus.saturated);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_bus.result_value !== want.value) begin
                        $error("result_value: expected %0d, actual %0d",
                               want.value, rsp_bus.result_value);
                        mismatch_count++;
                    end
                    if (rsp_bus.saturated !== want.sat) begin
                        $error("saturated: expected %0b, actual %0b",
                               want.sat, rsp_bus.saturated);
                        mismatch_count++;
                    end
                end
            end
            if (hold_request) begin
                stall_left   = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= no_idle || ($urandom_range(99) >= 20);
            end
        end
    end

    // Stimulus: reset, directed table, then random phases
    initial begin
        t_series_result   none;
        t_req_kind        kind;
        logic [DEG_W-1:0] deg;
        logic [DATA_W-1:0] scale;
        logic [DATA_W-1:0] offset;
        logic [IDX_W-1:0] idx;
        logic [DATA_W-1:0] cval;
        logic [DATA_W-1:0] x;
        bit               tame;

        none = '{default: '0};
        directed_rows = '{
            // after reset: empty table, degree zero
            typed_row(REQ_T_VALUE, 32'h0000_0000, 32'h0000_0000, 1'b0),
            typed_row(REQ_U_VALUE, 32'h7fff_ffff, 32'h0000_0000, 1'b0),
            typed_row(REQ_T_DERIV, 32'h8000_0000, 32'h0000_0000, 1'b0),
            // degree zero returns a0 unchanged, at both extremes
            item_row(REQ_WRITE, 6'd0, 32'h7fff_ffff, 32'h0),
            typed_row(REQ_T_VALUE, 32'h0001_2345, 32'h7fff_ffff, 1'b0),
            typed_row(REQ_U_VALUE, 32'h8000_0000, 32'h7fff_ffff, 1'b0),
            item_row(REQ_WRITE, 6'd0, 32'h8000_0000, 32'h0),
            typed_row(REQ_T_VALUE, 32'h7fff_ffff, 32'h8000_0000, 1'b0),
            typed_row(REQ_T_DERIV, 32'h0001_0000, 32'h0000_0000, 1'b0),
            item_row(REQ_WRITE, 6'd63, 32'h7fff_ffff, 32'h0),
            item_row(REQ_WRITE, 6'd1, 32'h0001_0000, 32'h0),
            // clipped coordinate: flag set even for a zero derivative
            cfg_row(REG_SCALE, 32'h7fff_ffff),
            cfg_row(REG_OFFSET, 32'h7fff_ffff),
            typed_row(REQ_T_DERIV, 32'h7fff_ffff, 32'h0000_0000, 1'b1),
            cfg_row(REG_DEGREE, 32'd1),
            item_row(REQ_T_VALUE, 6'd0, 32'h0, 32'h7fff_ffff),
            item_row(REQ_T_DERIV, 6'd0, 32'h0, 32'h8000_0000),
            item_row(REQ_U_VALUE, 6'd0, 32'h0, 32'h0000_0000),
            // full degree with negative extremes: intermediate clipping
            cfg_row(REG_DEGREE, 32'd63),
            cfg_row(REG_SCALE, 32'h8000_0000),
            cfg_row(REG_OFFSET, 32'h8000_0000),
            item_row(REQ_WRITE, 6'd62, 32'h7fff_ffff, 32'h0),
            item_row(REQ_WRITE, 6'd5, 32'h8000_0000, 32'h0),
            item_row(REQ_T_VALUE, 6'd0, 32'h0, 32'h0000_0000),
            item_row(REQ_T_DERIV, 6'd0, 32'h0, 32'h0000_0001),
            item_row(REQ_U_VALUE, 6'd0, 32'h0, 32'hffff_ffff)
        };

        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        req_bus.valid       <= 1'b0;
        req_bus.req_type    <= REQ_WRITE;
        req_bus.coeff_index <= '0;
        req_bus.coeff_value <= '0;
        req_bus.point_x     <= '0;
        foreach (coef_tab[i]) coef_tab[i] = '0;
        model_degree = '0;
        model_scale  = SCALE_RESET;
        model_offset = OFFSET_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_cfg) begin
                settle();
                cfg_write(directed_rows[r].reg_sel, directed_rows[r].cfg_data);
            end else begin
                send_item(directed_rows[r].kind, directed_rows[r].idx, directed_rows[r].cval,
                          directed_rows[r].x, directed_rows[r].typed, directed_rows[r].res);
            end
        end

        // Random phases, each with a fresh setting
        for (int phase = 0; phase < N_PHASES; phase++) begin
            settle();
            case (phase)
                0:       deg = 6'd63;
                1:       deg = 6'd0;
                2:       deg = 6'd1;
                3:       deg = 6'd3;
                default: deg = DEG_W'($urandom_range(2, 12));
            endcase
            tame = ($urandom_range(99) < 75);
            if (tame) begin
                scale  = $urandom_range(0, 131072) - 65536;
                offset = $urandom_range(0, 65536) - 32768;
            end else begin
                scale  = $urandom;
                offset = $urandom;
            end
            cfg_write(REG_DEGREE, {26'd0, deg});
            cfg_write(REG_SCALE, scale);
            cfg_write(REG_OFFSET, offset);

            // Hold off the result side so the block fills and closes its input
            if (phase == 3) hold_request = 1'b1;
            no_idle = (phase == 5);

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(99) < 30) kind = REQ_WRITE;
                else kind = t_req_kind'($urandom_range(1, 3));
                if ($urandom_range(99) < 80) idx = IDX_W'($urandom_range(0, deg));
                else idx = IDX_W'($urandom_range(0, MAX_DEGREE_DEF));
                cval = rand_value(1 << 18);
                x    = tame ? rand_value(1 << 16) : $urandom;
                send_item(kind, idx, cval, x, 1'b0, none);
            end
        end
        no_idle = 1'b0;

        // Drain, then watch for stray results
        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/cce_pkg.sv
sv/cce_req_if.sv
sv/cce_rsp_if.sv
sv/cce_regs.sv
sv/cce_coeff_mem.sv
sv/cce_engine.sv
sv/chebyshev_clenshaw_eval.sv
test/chebyshev_clenshaw_eval_tb.sv
